FILE: design/decimal_text_to_fixed_unit_defines.svh
// Assertion macros shared by the checker of the decimal text parser
`ifndef DECIMAL_TEXT_TO_FIXED_UNIT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_UNIT_DEFINES_SVH

// Implication in the same cycle, checking stops while reset is high
`define DTF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle, checking stops while reset is high
`define DTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication into the next cycle, checked through reset as well
`define DTF_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/dtf_pkg.sv
// Types, constants and the power-of-ten table of the decimal text parser
`default_nettype none
package dtf_pkg;

  localparam int DTF_FRAC_DIGITS = 9;

  localparam int INT_W   = 31;
  localparam int FRAC_W  = 30;
  localparam int CNT_W   = 4;
  localparam int QUO_W   = 16;
  localparam int VALUE_W = 48;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [INT_W-1:0] INT_MAX = '1;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } back_state_t;

  typedef struct packed {
    logic              negative;
    logic              clamped;
    logic [INT_W-1:0]  int_sum;
    logic [FRAC_W-1:0] frac_sum;
    logic [CNT_W-1:0]  frac_count;
  } job_t;

  function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    case (n)
      4'd0:    return 30'd1;
      4'd1:    return 30'd10;
      4'd2:    return 30'd100;
      4'd3:    return 30'd1000;
      4'd4:    return 30'd10000;
      4'd5:    return 30'd100000;
      4'd6:    return 30'd1000000;
      4'd7:    return 30'd10000000;
      4'd8:    return 30'd100000000;
      default: return 30'd1000000000;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: design/decimal_text_to_fixed_unit.sv
// Throughput: one character per cycle in; the converter starts a number only once the
//   last result is loaded, and its division unit yields two quotient bits a cycle.
// A two-entry queue absorbs bursts of short numbers; input stalls only when it is full.
// Reset (rst, synchronous, active high) returns the parser to skipping whitespace
//   and empties the queue and the output register.
`default_nettype none
module decimal_text_to_fixed_unit import dtf_pkg::*; #(
  parameter int FRAC_DIGITS = DTF_FRAC_DIGITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 char_valid,
  output logic                      char_ready,
  input  wire logic [7:0]           character,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output logic signed [VALUE_W-1:0] value,
  output logic                      saturated
);

  job_t push_data;
  job_t pop_data;
  logic push;
  logic pop;
  logic full;
  logic empty;

  dtf_front #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .character (character),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  dtf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  dtf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .value       (value),
    .saturated   (saturated)
  );

endmodule
`default_nettype wire

FILE: design/dtf_front.sv
// Character parser: classifies each byte, accumulates digits, queues finished numbers
`default_nettype none
module dtf_front import dtf_pkg::*; #(
  parameter int FRAC_DIGITS = DTF_FRAC_DIGITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_ready,
  input  wire logic [7:0] character,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_data
);

  localparam logic [CNT_W-1:0] FracLimit = CNT_W'(FRAC_DIGITS);

  phase_t            phase, phase_next;
  logic              negative, negative_next;
  logic [INT_W-1:0]  int_sum, int_sum_next;
  logic              clamped, clamped_next;
  logic [FRAC_W-1:0] frac_sum, frac_sum_next;
  logic [CNT_W-1:0]  frac_count, frac_count_next;

  logic              accept;
  logic              is_digit;
  logic              is_blank;
  logic [3:0]        digit;
  logic [INT_W+3:0]  int_wide;
  logic              int_over;
  logic [FRAC_W-1:0] frac_wide;
  logic              emit;

  assign char_ready = !q_full;
  assign accept     = char_valid && char_ready;
  assign is_digit   = (character >= CH_ZERO) && (character <= CH_NINE);
  assign is_blank   = (character == CH_SPACE) || ((character >= CH_TAB) && (character <= CH_CR));
  assign digit      = 4'(character - CH_ZERO);

  // times ten by shift-add
  assign int_wide  = ({4'b0, int_sum} << 3) + ({4'b0, int_sum} << 1) + (INT_W+4)'(digit);
  assign int_over  = clamped || (int_wide > {4'b0, INT_MAX});
  assign frac_wide = (frac_sum << 3) + (frac_sum << 1) + FRAC_W'(digit);

  assign q_data = '{negative: negative, clamped: clamped, int_sum: int_sum,
                    frac_sum: frac_sum, frac_count: frac_count};
  assign q_push = accept && emit;

  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    int_sum_next    = int_sum;
    clamped_next    = clamped;
    frac_sum_next   = frac_sum;
    frac_count_next = frac_count;
    emit            = 1'b0;
    case (phase)
      PH_INT: begin
        if (is_digit) begin
          int_sum_next = int_over ? INT_MAX : int_wide[INT_W-1:0];
          clamped_next = int_over;
        end else if (character == CH_POINT) begin
          phase_next = PH_FRAC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          // drop digits past the kept precision
          if (frac_count < FracLimit) begin
            frac_sum_next   = frac_wide;
            frac_count_next = frac_count + 1'b1;
          end
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_next = PH_SKIP;
        if (is_blank) begin
          phase_next = PH_SKIP;
        end else if (character == CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_INT;
        end else if (character == CH_PLUS) begin
          phase_next = PH_INT;
        end else if (is_digit) begin
          int_sum_next = int_over ? INT_MAX : int_wide[INT_W-1:0];
          clamped_next = int_over;
          phase_next   = PH_INT;
        end else if (character == CH_POINT) begin
          phase_next = PH_FRAC;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
    if (emit) begin
      phase_next      = PH_SKIP;
      negative_next   = 1'b0;
      int_sum_next    = '0;
      clamped_next    = 1'b0;
      frac_sum_next   = '0;
      frac_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIP;
      negative   <= 1'b0;
      int_sum    <= '0;
      clamped    <= 1'b0;
      frac_sum   <= '0;
      frac_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      negative   <= negative_next;
      int_sum    <= int_sum_next;
      clamped    <= clamped_next;
      frac_sum   <= frac_sum_next;
      frac_count <= frac_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/dtf_queue.sv
// Two-entry queue of finished numbers between parser and converter
`default_nettype none
module dtf_queue import dtf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: design/dtf_back.sv
// Converter: divides the fraction by a power of ten, two quotient bits a cycle
`default_nettype none
module dtf_back import dtf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  job_t                     q_data,
  output logic                     q_pop,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output logic signed [VALUE_W-1:0] value,
  output logic                     saturated
);

  localparam int StepW = $clog2(QUO_W / 2);
  localparam logic [StepW-1:0] LastStep = StepW'(QUO_W / 2 - 1);

  back_state_t       state, state_next;
  logic [FRAC_W-1:0] rem;
  logic [FRAC_W-1:0] divisor;
  logic [QUO_W-1:0]  quo;
  logic [StepW-1:0]  step;
  logic [INT_W-1:0]  int_sum;
  logic              negative;
  logic              clamped;

  logic [FRAC_W:0]   r1, r2;
  logic              ge1, ge2;
  logic [FRAC_W-1:0] rem1, rem2;
  logic              load_out;
  logic [VALUE_W-1:0] mag;

  // restoring division; the remainder stays below the divisor
  assign r1   = {rem, 1'b0};
  assign ge1  = r1 >= {1'b0, divisor};
  assign rem1 = ge1 ? FRAC_W'(r1 - {1'b0, divisor}) : r1[FRAC_W-1:0];
  assign r2   = {rem1, 1'b0};
  assign ge2  = r2 >= {1'b0, divisor};
  assign rem2 = ge2 ? FRAC_W'(r2 - {1'b0, divisor}) : r2[FRAC_W-1:0];

  // low 16 bits of the integer part are zero, so the quotient concatenates
  assign mag = {1'b0, int_sum, quo};

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == LastStep) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem      <= q_data.frac_sum;
      divisor  <= pow10(q_data.frac_count);
      quo      <= '0;
      step     <= '0;
      int_sum  <= q_data.int_sum;
      negative <= q_data.negative;
      clamped  <= q_data.clamped;
    end else if (state == BK_DIV) begin
      rem  <= rem2;
      quo  <= {quo[QUO_W-3:0], ge1, ge2};
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value     <= negative ? -mag : mag;
      saturated <= clamped;
    end
  end

endmodule
`default_nettype wire

FILE: design/dtf_checker.sv
// Port-level checks of the decimal text parser, bound to the top level
`default_nettype none
`include "decimal_text_to_fixed_unit_defines.svh"
module dtf_checker import dtf_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 char_valid,
  input wire logic                 char_ready,
  input wire logic [7:0]           character,
  input wire logic                 result_valid,
  input wire logic                 result_ready,
  input wire logic [VALUE_W-1:0]   value,
  input wire logic                 saturated
);

  `DTF_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(value) && $stable(saturated), "result changed while stalled")
  `DTF_ASSERT_NOW(a_sat_magnitude, clk, rst, result_valid && saturated && !value[VALUE_W-1], value[VALUE_W-2:QUO_W] == INT_MAX, "saturated result below the clamp")
  `DTF_ASSERT_RESET(a_reset_empty, clk, rst, !result_valid, "result valid right after reset")
  `DTF_ASSERT_RESET(a_reset_ready, clk, rst, char_ready, "input not ready right after reset")

endmodule

bind decimal_text_to_fixed_unit dtf_checker u_chk (.*);
`default_nettype wire

FILE: dv/fixed_value_checker.sv
// Scoreboard for the decimal text parser: predicts each Q31.16 result and checks the output
`timescale 1ns / 1ps
module fixed_value_checker import dtf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_valid,
  input  logic                      char_ready,
  input  logic [7:0]                character,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      saturated,
  output int                        mismatch_count,
  output int                        numbers_pending
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               saturated;
  } parsed_number_t;

  parsed_number_t expected_numbers[$];
  parsed_number_t oldest;
  int             fail_tally = 0;

  // Parser state as the stream has been seen so far
  phase_t            parse_phase;
  logic              minus_seen;
  logic [INT_W-1:0]  whole_part;
  logic              whole_clamped;
  logic [FRAC_W-1:0] frac_digits;
  logic [CNT_W-1:0]  frac_kept;

  initial begin
    mismatch_count  = 0;
    numbers_pending = 0;
  end

  task automatic start_over();
    parse_phase   = PH_SKIP;
    minus_seen    = 1'b0;
    whole_part    = '0;
    whole_clamped = 1'b0;
    frac_digits   = '0;
    frac_kept     = '0;
  endtask

  task automatic add_whole_digit(input logic [3:0] d);
    logic [34:0] grown;
    grown = 35'(whole_part) * 35'd10 + 35'(d);
    if (whole_clamped || grown > 35'(INT_MAX)) begin
      whole_part    = INT_MAX;
      whole_clamped = 1'b1;
    end else begin
      whole_part = grown[INT_W-1:0];
    end
  endtask

  task automatic add_fraction_digit(input logic [3:0] d);
    if (frac_kept < DTF_FRAC_DIGITS) begin
      frac_digits = frac_digits * 30'd10 + 30'(d);
      frac_kept   = frac_kept + 1'b1;
    end
  endtask

  // Scale the fraction to 16 bits, add the integer part, apply the sign
  task automatic finish_number();
    logic [63:0]    scale;
    logic [63:0]    magnitude;
    parsed_number_t num;
    scale = 64'd1;
    repeat (frac_kept) scale = scale * 64'd10;
    magnitude = (64'(whole_part) << 16) + ((64'(frac_digits) << 16) / scale);
    if (minus_seen) magnitude = 64'd0 - magnitude;
    num.value     = magnitude[VALUE_W-1:0];
    num.saturated = whole_clamped;
    expected_numbers.push_back(num);
    start_over();
  endtask

  task automatic take_char(input logic [7:0] c);
    logic is_digit;
    logic is_blank;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    case (parse_phase)
      PH_INT: begin
        if (is_digit) add_whole_digit(4'(c - CH_ZERO));
        else if (c == CH_POINT) parse_phase = PH_FRAC;
        else finish_number();
      end
      PH_FRAC: begin
        if (is_digit) add_fraction_digit(4'(c - CH_ZERO));
        else finish_number();
      end
      default: begin
        parse_phase = PH_SKIP;
        if (is_blank) begin
        end else if (c == CH_MINUS) begin
          minus_seen  = 1'b1;
          parse_phase = PH_INT;
        end else if (c == CH_PLUS) begin
          parse_phase = PH_INT;
        end else if (is_digit) begin
          add_whole_digit(4'(c - CH_ZERO));
          parse_phase = PH_INT;
        end else if (c == CH_POINT) begin
          parse_phase = PH_FRAC;
        end else begin
          finish_number();
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_over();
      expected_numbers.delete();
    end else begin
      // Check the output first: a result can never belong to the same transfer's character
      if (result_valid && result_ready) begin
        if (expected_numbers.size() == 0) begin
          $display("%0t: result value %0d saturated %0b with no number expected",
                   $time, $signed(value), saturated);
          fail_tally++;
        end else begin
          oldest = expected_numbers.pop_front();
          if (value !== oldest.value) begin
            $display("%0t: value expected %0d got %0d", $time,
                     $signed(oldest.value), $signed(value));
            fail_tally++;
          end
          if (saturated !== oldest.saturated) begin
            $display("%0t: saturated expected %0b got %0b", $time,
                     oldest.saturated, saturated);
            fail_tally++;
          end
        end
      end
      if (char_valid && char_ready) take_char(character);
    end
    mismatch_count  <= fail_tally;
    numbers_pending <= expected_numbers.size();
  end

endmodule

FILE: dv/testbench.sv
// Top of the decimal text parser bench: clock, reset, character stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import dtf_pkg::*;

  localparam int CHAR_TARGET = 1650;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_DEL_HI = 8'h80;
  localparam logic [7:0] CH_ALL_ONES = 8'hFF;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      char_valid = 1'b0;
  logic                      char_ready;
  logic [7:0]                character = 8'h00;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      saturated;

  int mismatch_count;
  int numbers_pending;
  int counted_chars = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit drained_mid = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  decimal_text_to_fixed_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .character    (character),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value        (value),
    .saturated    (saturated)
  );

  fixed_value_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_ready      (char_ready),
    .character       (character),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .value           (value),
    .saturated       (saturated),
    .mismatch_count  (mismatch_count),
    .numbers_pending (numbers_pending)
  );

  // Receiver stalls at random except during the calm stretch
  always @(posedge clk) begin
    result_ready <= calm || ($urandom_range(0, 99) >= 38);
  end

  task automatic send_char(input logic [7:0] c, input bit counted = 1'b1);
    while (!calm && $urandom_range(0, 99) < 38) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    character  <= c;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    if (counted) counted_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hold the sender off until every predicted result has come out
  task automatic drain_results();
    char_valid <= 1'b0;
    @(posedge clk);
    while (numbers_pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // Blanks, optional sign, digits, optional point and fraction, then some terminator
  task automatic send_number();
    int n_lead;
    int n_int;
    int n_frac;
    int r;
    n_lead = $urandom_range(0, 3);
    repeat (n_lead) send_char(any_blank());
    r = $urandom_range(0, 3);
    if (r == 0) send_char(CH_MINUS);
    else if (r == 1) send_char(CH_PLUS);
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 5);
    repeat (n_int) send_char(any_digit());
    if ($urandom_range(0, 2) != 0) begin
      send_char(CH_POINT);
      n_frac = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
      repeat (n_frac) send_char(any_digit());
    end
    r = $urandom_range(0, 9);
    if (r < 4) send_char(any_blank());
    else if (r == 4) send_char(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
    else if (r == 5) send_char(CH_POINT);
    else send_char(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Overflowing negative with excess fraction digits, ended by a line feed
    send_char(CH_SPACE, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_text("-9999999999.1234567899");
    send_char(CH_LF);
    send_text("2147483647 ");
    // Sign ends a fraction, sign ends an integer, second point, lone junk
    send_text("+0.5-7+1.2.x-");
    send_char(CH_NUL);
    send_char(CH_POINT);
    send_char(CH_ALL_ONES);
    send_char(CH_VT, 1'b0);
    send_char(CH_FF, 1'b0);
    send_char(CH_CR, 1'b0);
    send_text("3");
    send_char(CH_DEL_HI);
    drain_results();

    counted_chars = 0;
    while (counted_chars < CHAR_TARGET) begin
      calm = (counted_chars >= 700) && (counted_chars < 1000);
      if (!drained_mid && counted_chars >= 1200) begin
        drain_results();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
      end else begin
        send_number();
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && numbers_pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/dtf_pkg.sv
design/dtf_front.sv
design/dtf_queue.sv
design/dtf_back.sv
design/decimal_text_to_fixed_unit.sv
design/dtf_checker.sv
dv/fixed_value_checker.sv
dv/testbench.sv
